// ===== design/ble_ad_structure_parser_top_defines.svh =====
// Assertion macros for the advertising-data parser.
`ifndef BLE_AD_STRUCTURE_PARSER_TOP_DEFINES_SVH
`define BLE_AD_STRUCTURE_PARSER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define BAP_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define BAP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BAP_ASSERT_IMPL(label, clk, rst, ante, cons)
`define BAP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== design/bap_pkg.sv =====
package bap_pkg;
  localparam int UuidSlots = 4;
  localparam int StageDepth = 25;
  localparam logic [15:0] CompanyBeacon = 16'h004C;
  localparam logic [7:0] KindFlags = 8'h01;
  localparam logic [7:0] KindUuid16Part = 8'h02;
  localparam logic [7:0] KindUuid16Full = 8'h03;
  localparam logic [7:0] KindUuid32Part = 8'h04;
  localparam logic [7:0] KindUuid32Full = 8'h05;
  localparam logic [7:0] KindUuid128Part = 8'h06;
  localparam logic [7:0] KindUuid128Full = 8'h07;
  localparam logic [7:0] KindTxPower = 8'h0A;
  localparam logic [7:0] KindSvcData = 8'h16;
  localparam logic [7:0] KindAppearance = 8'h19;
  localparam logic [7:0] KindMfr = 8'hFF;
  localparam logic [7:0] BeaconType = 8'h02;
  localparam logic [7:0] BeaconLen = 8'h15;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [6:0]  presence_mask;
    logic [7:0]  flags_value;
    logic signed [7:0] power_level;
    logic [15:0] company_id;
    logic [15:0] appearance;
    logic [63:0] uuid_list;
    logic [2:0]  uuid_total;
    logic [23:0] svc_info;
    logic [31:0] beacon_major_minor;
    logic signed [7:0] beacon_power;
    logic [63:0] beacon_uuid_high;
    logic [63:0] beacon_uuid_low;
  } out_word_t;
endpackage

// ===== design/bap_stream_if.sv =====
interface bap_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== design/bap_core.sv =====
// Byte-at-a-time structure walker; record registers update in the accept cycle.
module bap_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  bap_pkg::in_word_t in_word,
  output bap_pkg::out_word_t rec
);
  import bap_pkg::*;

  logic        report_start, parse_stopped;
  logic [7:0]  struct_position, struct_length, struct_kind, pending_low_byte;
  logic [7:0]  staged_payload [StageDepth];
  logic [15:0] staged_uuid_slots [UuidSlots];
  logic [2:0]  staged_uuid_count;
  logic [6:0]  presence_bits;
  logic [7:0]  flags_reg, power_reg, beacon_power_reg;
  logic [15:0] company_reg, appearance_reg;
  logic [15:0] uuid_slots [UuidSlots];
  logic [2:0]  uuid_slot_count;
  logic [23:0] service_data_reg;
  logic [63:0] beacon_hi_reg, beacon_lo_reg;
  logic [31:0] beacon_major_minor_reg;

  // Effective state after the report-start clear.
  logic        stop_eff;
  logic [7:0]  pos_eff;
  logic [6:0]  pres_eff;
  logic [2:0]  cnt_eff, scnt_eff;
  logic        clr;
  logic [7:0]  b, idx, plen, kind_eff;
  logic        is_u16, dup, last_payload, tail;
  logic [15:0] new_uuid;
  logic [7:0]  p0, p1, p2, p3;
  logic        beacon_hit;
  logic [63:0] hi_w, lo_w;

  always_comb begin
    clr = report_start;
    b = in_word.data_byte;
    stop_eff = clr ? 1'b0 : parse_stopped;
    pos_eff = clr ? 8'd0 : struct_position;
    pres_eff = clr ? 7'd0 : presence_bits;
    cnt_eff = clr ? 3'd0 : uuid_slot_count;
    scnt_eff = clr ? 3'd0 : staged_uuid_count;
    idx = pos_eff - 8'd2;
    plen = struct_length - 8'd1;
    // A one-byte structure ends on its type byte, so the type is taken from the bus.
    kind_eff = (pos_eff == 8'd1) ? b : struct_kind;
    is_u16 = (struct_kind == KindUuid16Part) || (struct_kind == KindUuid16Full);
    new_uuid = {b, pending_low_byte};
    dup = 1'b0;
    for (int i = 0; i < UuidSlots; i++) begin
      if ((3'(i) < scnt_eff) && (staged_uuid_slots[i] == new_uuid)) dup = 1'b1;
    end
    // The current byte may be the last payload byte; forward it into reads.
    tail = (pos_eff >= 8'd2) && (pos_eff == struct_length);
    p0 = (tail && idx == 8'd0) ? b : staged_payload[0];
    p1 = (tail && idx == 8'd1) ? b : staged_payload[1];
    p2 = (tail && idx == 8'd2) ? b : staged_payload[2];
    p3 = (tail && idx == 8'd3) ? b : staged_payload[3];
    last_payload = tail;
    for (int i = 0; i < 8; i++) begin
      hi_w[63-8*i -: 8] = staged_payload[4+i];
      lo_w[63-8*i -: 8] = staged_payload[12+i];
    end
    beacon_hit = ({p1, p0} == CompanyBeacon) && (plen >= 8'(StageDepth))
      && (p2 == BeaconType) && (p3 == BeaconLen);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      report_start <= 1'b1;
      parse_stopped <= 1'b0;
      struct_position <= '0;
      struct_length <= '0;
      struct_kind <= '0;
      pending_low_byte <= '0;
      staged_uuid_count <= '0;
      presence_bits <= '0;
      flags_reg <= '0;
      power_reg <= '0;
      company_reg <= '0;
      appearance_reg <= '0;
      uuid_slot_count <= '0;
      service_data_reg <= '0;
      beacon_hi_reg <= '0;
      beacon_lo_reg <= '0;
      beacon_major_minor_reg <= '0;
      beacon_power_reg <= '0;
      for (int i = 0; i < UuidSlots; i++) begin
        staged_uuid_slots[i] <= '0;
        uuid_slots[i] <= '0;
      end
    end else if (take) begin
      report_start <= in_word.last_byte;
      if (clr) begin
        parse_stopped <= 1'b0;
        struct_position <= '0;
        staged_uuid_count <= '0;
        presence_bits <= '0;
        flags_reg <= '0;
        power_reg <= '0;
        company_reg <= '0;
        appearance_reg <= '0;
        uuid_slot_count <= '0;
        service_data_reg <= '0;
        beacon_hi_reg <= '0;
        beacon_lo_reg <= '0;
        beacon_major_minor_reg <= '0;
        beacon_power_reg <= '0;
        for (int i = 0; i < UuidSlots; i++) uuid_slots[i] <= '0;
      end
      if (!stop_eff) begin
        if (pos_eff == 8'd0) begin
          if (b == 8'd0) begin
            parse_stopped <= 1'b1;
          end else begin
            struct_length <= b;
            struct_position <= 8'd1;
          end
        end else begin
          if (pos_eff == 8'd1) begin
            struct_kind <= b;
            for (int i = 0; i < UuidSlots; i++) staged_uuid_slots[i] <= uuid_slots[i];
            staged_uuid_count <= cnt_eff;
            pending_low_byte <= '0;
          end else begin
            if (idx < 8'(StageDepth)) staged_payload[idx[4:0]] <= b;
            if (is_u16) begin
              if (!idx[0]) begin
                pending_low_byte <= b;
              end else if (!dup && scnt_eff < 3'(UuidSlots)) begin
                staged_uuid_slots[scnt_eff[1:0]] <= new_uuid;
                staged_uuid_count <= scnt_eff + 3'd1;
              end
            end
          end
          if (pos_eff == struct_length) begin
            struct_position <= '0;
            // Commit the finished structure.
            case (kind_eff)
              KindFlags: if (plen >= 8'd1) begin
                presence_bits <= pres_eff | 7'h01; flags_reg <= p0;
              end
              KindTxPower: if (plen >= 8'd1) begin
                presence_bits <= pres_eff | 7'h02; power_reg <= p0;
              end
              KindUuid16Part, KindUuid16Full: begin
                // An empty list leaves the slots as they are.
                if (pos_eff != 8'd1) begin
                  for (int i = 0; i < UuidSlots; i++) uuid_slots[i] <= staged_uuid_slots[i];
                  uuid_slot_count <= scnt_eff;
                  if (last_payload && idx[0] && !dup && scnt_eff < 3'(UuidSlots)) begin
                    uuid_slots[scnt_eff[1:0]] <= new_uuid;
                    uuid_slot_count <= scnt_eff + 3'd1;
                  end
                end
              end
              KindUuid32Part, KindUuid32Full: presence_bits <= pres_eff | 7'h10;
              KindUuid128Part, KindUuid128Full: presence_bits <= pres_eff | 7'h20;
              KindSvcData: if (plen >= 8'd2) begin
                service_data_reg <= {p1, p0, (plen >= 8'd3) ? p2 : 8'd0};
              end
              KindAppearance: if (plen >= 8'd2) begin
                presence_bits <= pres_eff | 7'h40; appearance_reg <= {p1, p0};
              end
              KindMfr: if (plen >= 8'd2) begin
                company_reg <= {p1, p0};
                if (beacon_hit) begin
                  presence_bits <= pres_eff | 7'h0C;
                  beacon_hi_reg <= hi_w;
                  beacon_lo_reg <= lo_w;
                  beacon_major_minor_reg <= {staged_payload[20], staged_payload[21],
                    staged_payload[22], staged_payload[23]};
                  beacon_power_reg <= (tail && idx == 8'd24) ? b : staged_payload[24];
                end else begin
                  presence_bits <= pres_eff | 7'h04;
                end
              end
              default: ;
            endcase
          end else begin
            struct_position <= pos_eff + 8'd1;
          end
        end
      end
    end
  end

  // Pack the record; slots at and above the count read zero.
  always_comb begin
    rec.presence_mask = presence_bits;
    rec.flags_value = flags_reg;
    rec.power_level = power_reg;
    rec.company_id = company_reg;
    rec.appearance = appearance_reg;
    rec.uuid_list = '0;
    for (int i = 0; i < UuidSlots; i++) begin
      if (3'(i) < uuid_slot_count) rec.uuid_list[16*i +: 16] = uuid_slots[i];
    end
    rec.uuid_total = uuid_slot_count;
    rec.svc_info = service_data_reg;
    rec.beacon_major_minor = beacon_major_minor_reg;
    rec.beacon_power = beacon_power_reg;
    rec.beacon_uuid_high = beacon_hi_reg;
    rec.beacon_uuid_low = beacon_lo_reg;
  end
endmodule

// ===== design/bap_out_stage.sv =====
// Two-entry skid buffer holding finished records.
module bap_out_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  bap_pkg::out_word_t data,
  output logic               room,
  bap_stream_if.source       m
);
  import bap_pkg::*;

  out_word_t mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic [1:0] count_next;
  logic       pop;

  // Room means an entry is still free after this edge's push and pop.
  assign pop = m.valid && m.ready;
  assign count_next = count + {1'b0, push} - {1'b0, pop};
  assign room = (count_next != 2'd2);
  assign m.valid = (count != 2'd0);
  assign m.payload = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= data;
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count_next;
    end
  end
endmodule

// ===== design/ble_ad_structure_parser_top.sv =====
// Advertising-data parser: takes one report byte per cycle while input
// ready is high and updates the parsed record in the same cycle; the record
// of a report is registered through push_d after its last byte is accepted,
// written to the two-word output buffer and offered on the output once the
// buffer has registered it. Input ready drops only when the output buffer
// would be full after the current edge, i.e. only while the sink stalls.
`include "ble_ad_structure_parser_top_defines.svh"
module ble_ad_structure_parser_top (
  input logic          clk,
  input logic          rst,
  bap_stream_if.sink   in_ch,
  bap_stream_if.source out_ch
);
  import bap_pkg::*;

  logic      take, room, push;
  out_word_t rec;
  logic      push_d;

  // A word is taken when the buffer has room for the record it may make.
  assign in_ch.ready = room;
  assign take = in_ch.valid && in_ch.ready;

  bap_core u_core (
    .clk(clk), .rst(rst), .take(take), .in_word(in_ch.payload), .rec(rec)
  );

  // The record is pushed the cycle after the last word updates it.
  always_ff @(posedge clk) begin
    if (rst) push_d <= 1'b0;
    else push_d <= take && in_ch.payload.last_byte;
  end
  assign push = push_d;

  bap_out_stage u_out (
    .clk(clk), .rst(rst), .push(push), .data(rec), .room(room), .m(out_ch)
  );

  `BAP_ASSERT_IMPL(a_no_take_full, clk, rst, !room, !take)
  `BAP_ASSERT_NEXT(a_push_after_last, clk, rst, take && in_ch.payload.last_byte, push)
  `BAP_ASSERT_IMPL(a_count_range, clk, rst, out_ch.valid, rec.uuid_total <= 3'd4)
endmodule
